>>> hw/rtl/sesd_pkg.sv
package sesd_pkg;

   localparam int AccWidthDefault = 32;
   localparam int RspDepth        = 4;

   localparam logic [7:0] HashChar = 8'h23;
   localparam int         WidthLimit = 60;

   localparam logic [1:0] StatusOk        = 2'd0;
   localparam logic [1:0] StatusBadHeader = 2'd1;
   localparam logic [1:0] StatusTooShort  = 2'd2;
   localparam logic [1:0] StatusChecksum  = 2'd3;

   localparam logic KindEvent  = 1'b0;
   localparam logic KindStatus = 1'b1;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [31:0] event_time;
      logic signed [31:0] event_distance;
      logic [1:0]         status;
      logic               stopped_early;
      logic               last_result;
   } rsp_type;

   // results of one character, event first then status
   typedef struct packed {
      logic    ev_valid;
      logic    st_valid;
      rsp_type ev;
      rsp_type st;
   } push_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } digit_type;

   function automatic digit_type b64_digit(input logic [7:0] c);
      digit_type r;
      r.valid = 1'b1;
      r.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.value = 6'd62;
      end else if (c == 8'h2F) begin
         r.value = 6'd63;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

   // tens of a width digit, exact for values below 64
   function automatic logic [2:0] width_tens(input logic [5:0] w);
      logic [13:0] prod;
      prod = 14'(w) * 14'd205;
      return 3'(prod >> 11);
   endfunction

   function automatic logic [3:0] width_units(input logic [5:0] w);
      logic [5:0] tens_x10;
      tens_x10 = 6'(width_tens(w)) * 6'd10;
      return 4'(w - tens_x10);
   endfunction

endpackage

>>> hw/rtl/scroll_event_stream_decoder.sv
// scroll event string decoder
// request channel: one character per transaction (char_code, last_char), taken at an
//   edge where req_valid is high and req_stall is low
// response channel: one transaction per decoded record (result_kind event, running
//   time and distance), then one status transaction on the last character of the
//   string (ok, bad header, too short, checksum mismatch, plus stopped_early)
// on a nonzero status the consumer should drop the events of that string
// latency: a character is registered at acceptance and decoded in the next cycle,
//   so its results show on rsp_valid one cycle after the accepting edge
// throughput: one character per cycle; the response queue drains one transaction
//   per cycle, and a character yields at most two (event plus status)
// rsp_stall: results collect in a four-entry response queue; once it cannot take
//   two more the held character waits and req_stall goes high
// reset: synchronous, clears the decoder to the header phase, empties the queue
//   and drops any held character; after a string's last character the decoder
//   returns to the same state by itself
module scroll_event_stream_decoder #(
   parameter int AccWidth = sesd_pkg::AccWidthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sesd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sesd_pkg::rsp_type rsp_payload
);
   import sesd_pkg::*;

   // input register
   logic     in_valid_ff, in_valid_in;
   req_type  in_item_ff;
   logic     req_accept;
   logic     space_ok;
   logic     step;
   push_type push;

   // the held character moves on whenever the queue has room for two results
   assign step       = in_valid_ff & space_ok;
   assign req_stall  = in_valid_ff & ~space_ok;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_payload;
      end
   end

   // per-character decode and running state
   sesd_decode #(
      .AccWidth(AccWidth)
   ) u_decode (
      .clock(clock),
      .reset(reset),
      .step (step),
      .item (in_item_ff),
      .push (push)
   );

   // response queue, skid between decode and consumer
   sesd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space_ok   (space_ok),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // a status transaction always closes the string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.result_kind == KindStatus) |-> rsp_payload.last_result)
   else $error("status result without last_result");

   // event transactions carry no status information
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.result_kind == KindEvent) |->
         (rsp_payload.status == StatusOk && !rsp_payload.stopped_early
          && !rsp_payload.last_result))
   else $error("event result with status fields set");

   // nothing comes out in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("response valid right after reset");

   // a character is only held back while one is already waiting
   assert property (@(posedge clock) disable iff (reset)
      (req_stall && !$past(reset)) |-> $past(req_valid || in_valid_ff))
   else $error("request stalled with no character in flight");

endmodule

>>> hw/rtl/sesd_rsp_queue.sv
module sesd_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  sesd_pkg::push_type push,
   output logic               space_ok,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sesd_pkg::rsp_type  rsp_payload
);
   import sesd_pkg::*;

   localparam int PtrW   = $clog2(RspDepth);
   localparam int CountW = $clog2(RspDepth + 1);

   rsp_type           mem_ff [RspDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [PtrW-1:0]   wr_next;
   logic              first_valid, second_valid, pop;
   rsp_type           first_item;
   logic [1:0]        n_push;

   // compact the pair so the first slot is always used first
   assign first_valid  = push.ev_valid | push.st_valid;
   assign second_valid = push.ev_valid & push.st_valid;
   assign first_item   = push.ev_valid ? push.ev : push.st;
   assign n_push       = {1'b0, first_valid} + {1'b0, second_valid};

   assign wr_next   = wr_ptr_ff + PtrW'(1);
   assign rsp_valid = (count_ff != '0);
   assign rsp_payload = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   assign space_ok  = (count_ff <= CountW'(RspDepth - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + CountW'(n_push) - CountW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (first_valid) begin
         mem_ff[wr_ptr_ff] <= first_item;
      end
      if (second_valid) begin
         mem_ff[wr_next] <= push.st;
      end
   end

endmodule

>>> hw/rtl/sesd_decode.sv
module sesd_decode #(
   parameter int AccWidth = sesd_pkg::AccWidthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  sesd_pkg::req_type  item,
   output sesd_pkg::push_type push
);
   import sesd_pkg::*;

   localparam int ExtW = (AccWidth > 32) ? AccWidth : 32;

   typedef enum logic [6:0] {
      PH_HEADER   = 7'b0000001,
      PH_CHECK_HI = 7'b0000010,
      PH_CHECK_LO = 7'b0000100,
      PH_WIDTH    = 7'b0001000,
      PH_TIME     = 7'b0010000,
      PH_DIST     = 7'b0100000,
      PH_STOPPED  = 7'b1000000
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [7:0]          sum_ff, sum_in;
   logic [11:0]         check_ff, check_in;
   logic [AccWidth-1:0] digit_ff, digit_in;
   logic [3:0]          tleft_ff, tleft_in;
   logic [2:0]          dleft_ff, dleft_in;
   logic [31:0]         tdelta_ff, tdelta_in;
   logic [31:0]         rtime_ff, rtime_in;
   logic [31:0]         rdist_ff, rdist_in;
   logic                header_bad_ff, header_bad_in;
   logic                stopped_ff, stopped_in;

   digit_type           dig;
   logic [AccWidth-1:0] digit_new;
   logic [ExtW-1:0]     digit_ext;
   logic [31:0]         td_cur;
   logic [31:0]         dist_add;
   logic [3:0]          tl_dec;
   logic [2:0]          dl_dec;
   logic                complete;
   logic                width_bad;
   logic                sum_en;
   logic                early;

   assign dig       = b64_digit(item.char_code);
   assign digit_new = dig.valid ? {digit_ff[AccWidth-7:0], dig.value} : digit_ff;
   assign digit_ext = ExtW'(digit_new);
   assign tl_dec    = tleft_ff - 4'(tleft_ff != '0);
   assign dl_dec    = dleft_ff - 3'(dleft_ff != '0);
   assign width_bad = ~dig.valid || (dig.value == 6'd0) || (dig.value >= 6'(WidthLimit))
                      || item.last_char;
   assign sum_en    = (phase_ff == PH_WIDTH) || (phase_ff == PH_TIME)
                      || (phase_ff == PH_DIST) || (phase_ff == PH_STOPPED);
   assign early     = (phase_ff == PH_HEADER) || (phase_ff == PH_CHECK_HI);

   always_comb begin
      phase_in      = phase_ff;
      sum_in        = sum_ff;
      check_in      = check_ff;
      digit_in      = digit_ff;
      tleft_in      = tleft_ff;
      dleft_in      = dleft_ff;
      tdelta_in     = tdelta_ff;
      rtime_in      = rtime_ff;
      rdist_in      = rdist_ff;
      header_bad_in = header_bad_ff;
      stopped_in    = stopped_ff;
      complete      = 1'b0;
      td_cur        = tdelta_ff;
      dist_add      = '0;
      push          = '0;

      if (step) begin
         if (sum_en) begin
            sum_in = sum_ff + item.char_code;
         end
         unique case (phase_ff)
            PH_HEADER: begin
               if (item.char_code == HashChar) begin
                  phase_in = PH_CHECK_HI;
               end else begin
                  header_bad_in = 1'b1;
                  phase_in      = PH_STOPPED;
               end
            end
            PH_CHECK_HI, PH_CHECK_LO: begin
               if (dig.valid) begin
                  check_in = {check_ff[5:0], dig.value};
               end
               phase_in = (phase_ff == PH_CHECK_HI) ? PH_CHECK_LO : PH_WIDTH;
            end
            PH_WIDTH: begin
               if (width_bad) begin
                  stopped_in = 1'b1;
                  phase_in   = PH_STOPPED;
               end else begin
                  tleft_in = width_units(dig.value);
                  dleft_in = width_tens(dig.value);
                  digit_in = '0;
                  phase_in = (width_units(dig.value) != '0) ? PH_TIME : PH_DIST;
               end
            end
            PH_TIME, PH_DIST: begin
               digit_in = digit_new;
               dist_add = digit_ext[31:0];
               if (phase_ff == PH_TIME) begin
                  tleft_in = tl_dec;
                  if (tl_dec == '0) begin
                     // time field done, distance starts from zero
                     td_cur    = digit_ext[31:0];
                     tdelta_in = digit_ext[31:0];
                     digit_in  = '0;
                     dist_add  = '0;
                     if (dleft_ff == '0) begin
                        complete = 1'b1;
                     end else begin
                        phase_in = PH_DIST;
                     end
                  end
               end else begin
                  dleft_in = dl_dec;
                  if (dl_dec == '0) begin
                     complete = 1'b1;
                  end
               end
               if (complete) begin
                  rtime_in  = rtime_ff + td_cur;
                  rdist_in  = rdist_ff + dist_add;
                  tdelta_in = '0;
                  digit_in  = '0;
                  phase_in  = PH_WIDTH;
                  push.ev_valid          = 1'b1;
                  push.ev.result_kind    = KindEvent;
                  push.ev.event_time     = rtime_ff + td_cur;
                  push.ev.event_distance = rdist_ff + dist_add;
                  push.ev.status         = StatusOk;
               end else if (item.last_char) begin
                  stopped_in = 1'b1;
                  phase_in   = PH_STOPPED;
               end
            end
            PH_STOPPED: begin
               phase_in = PH_STOPPED;
            end
            default: begin
               phase_in = PH_STOPPED;
            end
         endcase

         if (item.last_char) begin
            push.st_valid       = 1'b1;
            push.st.result_kind = KindStatus;
            push.st.last_result = 1'b1;
            priority if (header_bad_in) begin
               push.st.status = StatusBadHeader;
            end else if (early) begin
               push.st.status = StatusTooShort;
            end else begin
               push.st.status        = (check_in[7:0] == sum_in) ? StatusOk : StatusChecksum;
               push.st.stopped_early = stopped_in;
            end
            // string over, back to the reset state
            phase_in      = PH_HEADER;
            sum_in        = '0;
            check_in      = '0;
            digit_in      = '0;
            tleft_in      = '0;
            dleft_in      = '0;
            tdelta_in     = '0;
            rtime_in      = '0;
            rdist_in      = '0;
            header_bad_in = 1'b0;
            stopped_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         sum_ff        <= '0;
         check_ff      <= '0;
         digit_ff      <= '0;
         tleft_ff      <= '0;
         dleft_ff      <= '0;
         tdelta_ff     <= '0;
         rtime_ff      <= '0;
         rdist_ff      <= '0;
         header_bad_ff <= 1'b0;
         stopped_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         sum_ff        <= sum_in;
         check_ff      <= check_in;
         digit_ff      <= digit_in;
         tleft_ff      <= tleft_in;
         dleft_ff      <= dleft_in;
         tdelta_ff     <= tdelta_in;
         rtime_ff      <= rtime_in;
         rdist_ff      <= rdist_in;
         header_bad_ff <= header_bad_in;
         stopped_ff    <= stopped_in;
      end
   end

endmodule

>>> test/tb_scroll_event_stream_decoder.sv
module tb_scroll_event_stream_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import sesd_pkg::*;

   // cycles with no transaction on either channel before the run is abandoned
   localparam int IdleLimit    = 600;
   localparam int RandomChars  = 740;
   // allowance for results still passing through the input register and response queue
   localparam int DrainCycles  = 10;

   // decoder phases, in the order the string walks through them
   typedef enum logic [2:0] {
      PhaseHeader,
      PhaseCheckHi,
      PhaseCheckLo,
      PhaseWidth,
      PhaseTime,
      PhaseDistance,
      PhaseStopped
   } phase_type;

   // one character in flight, with the status it must end in where that is fixed by hand
   typedef struct {
      req_type    req;
      bit         pinned;
      logic [1:0] pin_status;
      logic       pin_stop;
   } sent_char_type;

   typedef struct {
      string      text;
      bit         seal;
      bit         pinned;
      logic [1:0] pin_status;
      logic       pin_stop;
   } row_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // decoder state mirrored by the checker
   phase_type   dec_phase;
   logic [7:0]  char_total;
   logic [11:0] check_value;
   logic [31:0] digit_acc;
   logic [3:0]  time_left;
   logic [2:0]  dist_left;
   logic [31:0] time_delta;
   logic [31:0] run_time;
   logic [31:0] run_dist;
   bit          hdr_bad;
   bit          parse_stopped;

   rsp_type       results_due[$];
   sent_char_type chars_in_flight[$];
   logic [7:0]    line_chars[$];

   int mismatch_count = 0;
   int idle_cycles    = 0;
   int send_quiet     = 0;
   int take_quiet     = 0;

   // directed strings; '-' marks check digits that are filled in from the real sum
   row_type directed_rows [0:16] = '{
      '{"Z",        1'b0, 1'b1, StatusBadHeader, 1'b0},  // lone character that is not a hash
      '{"B#AAB/",   1'b0, 1'b1, StatusBadHeader, 1'b0},  // bad header, rest only consumed
      '{"#",        1'b0, 1'b1, StatusTooShort,  1'b0},  // hash alone
      '{"#/",       1'b0, 1'b1, StatusTooShort,  1'b0},  // hash and one check digit
      '{"#AA",      1'b0, 1'b1, StatusOk,        1'b0},  // header only, empty sum
      '{"#A/",      1'b0, 1'b1, StatusChecksum,  1'b0},  // header only, check disagrees
      '{"#--B/",    1'b1, 1'b0, StatusOk,        1'b0},  // one time digit at its largest
      // widest record twice, both deltas overflow the accumulator, then distance only
      '{"#--7//////////////7//////////////K/", 1'b1, 1'b0, StatusOk, 1'b0},
      '{"#--Z+/Aaz09", 1'b1, 1'b0, StatusOk,     1'b0},  // time and distance, mixed digits
      '{"#--C!BK*", 1'b1, 1'b0, StatusOk,        1'b0},  // digits outside the alphabet
      '{"#--BAA",   1'b1, 1'b0, StatusOk,        1'b0},  // zero width stops parsing
      '{"#--8BB",   1'b1, 1'b0, StatusOk,        1'b0},  // width sixty
      '{"#--/B",    1'b1, 1'b0, StatusOk,        1'b0},  // width sixty-three
      '{"#--!B",    1'b1, 1'b0, StatusOk,        1'b0},  // width outside the alphabet
      '{"#--L/",    1'b1, 1'b0, StatusOk,        1'b0},  // ends between time and distance
      '{"#--B",     1'b1, 1'b0, StatusOk,        1'b0},  // ends on a width digit
      '{"#!!B/",    1'b0, 1'b0, StatusOk,        1'b0}   // unreadable check digits
   };

   scroll_event_stream_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // queue helpers
   // ---------------------------------------------------------------------------------

   function automatic void add_char(input logic [7:0] c);
      line_chars.insert(line_chars.size(), c);
   endfunction

   function automatic void add_result(input rsp_type r);
      results_due.insert(results_due.size(), r);
   endfunction

   // ---------------------------------------------------------------------------------
   // base64 helpers
   // ---------------------------------------------------------------------------------

   // digit value of a character, -1 outside the alphabet
   function automatic int char_to_digit(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c - "A");
      if (c >= "a" && c <= "z") return int'(c - "a") + 26;
      if (c >= "0" && c <= "9") return int'(c - "0") + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
   endfunction

   function automatic logic [7:0] digit_char(input int v);
      if (v < 26) return "A" + 8'(v);
      if (v < 52) return "a" + 8'(v - 26);
      if (v < 62) return "0" + 8'(v - 52);
      if (v == 62) return "+";
      return "/";
   endfunction

   function automatic logic [7:0] non_alpha_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (char_to_digit(c) >= 0);
      return c;
   endfunction

   // overwrite the two check digits with the sum of everything after them; only the
   // low eight bits of the check take part, so the top of the first digit may vary
   function automatic void seal_check(input bit vary_hi);
      logic [7:0] total;
      total = '0;
      if (line_chars.size() < 3) return;
      for (int i = 3; i < line_chars.size(); i++) total += line_chars[i];
      line_chars[1] = digit_char(vary_hi ? int'({4'($urandom_range(0, 15)), total[7:6]})
                                         : int'(total[7:6]));
      line_chars[2] = digit_char(int'(total[5:0]));
   endfunction

   // ---------------------------------------------------------------------------------
   // decoder prediction
   // ---------------------------------------------------------------------------------

   function automatic void clear_decoder();
      dec_phase     = PhaseHeader;
      char_total    = '0;
      check_value   = '0;
      digit_acc     = '0;
      time_left     = '0;
      dist_left     = '0;
      time_delta    = '0;
      run_time      = '0;
      run_dist      = '0;
      hdr_bad       = 1'b0;
      parse_stopped = 1'b0;
   endfunction

   // works out the events and status caused by one character and queues them
   function automatic void decode_char(input req_type r);
      int        d;
      phase_type start_phase;
      bit        complete;
      rsp_type   res;
      d           = char_to_digit(r.char_code);
      start_phase = dec_phase;
      complete    = 1'b0;
      // everything from the fourth character on is summed, stopped or not (after a bad header, from the second)
      if (dec_phase >= PhaseWidth) char_total += r.char_code;
      case (dec_phase)
         PhaseHeader: begin
            if (r.char_code == HashChar) begin
               dec_phase = PhaseCheckHi;
            end else begin
               hdr_bad   = 1'b1;
               dec_phase = PhaseStopped;
            end
         end
         PhaseCheckHi, PhaseCheckLo: begin
            // an unreadable check digit still uses up its position
            if (d >= 0) check_value = {check_value[5:0], 6'(d)};
            dec_phase = (dec_phase == PhaseCheckHi) ? PhaseCheckLo : PhaseWidth;
         end
         PhaseWidth: begin
            // a width on the last character can never be followed by its digits
            if (d <= 0 || d >= WidthLimit || r.last_char) begin
               parse_stopped = 1'b1;
               dec_phase     = PhaseStopped;
            end else begin
               time_left = 4'(d % 10);
               dist_left = 3'(d / 10);
               digit_acc = '0;
               dec_phase = (time_left != 0) ? PhaseTime : PhaseDistance;
            end
         end
         PhaseTime, PhaseDistance: begin
            // big-endian shift-add, wrapping at the accumulator width
            if (d >= 0) digit_acc = (digit_acc << 6) | 32'(d);
            if (dec_phase == PhaseTime) begin
               if (time_left != 0) time_left--;
               if (time_left == 0) begin
                  time_delta = digit_acc;
                  digit_acc  = '0;
                  if (dist_left == 0) complete = 1'b1;
                  else dec_phase = PhaseDistance;
               end
            end else begin
               if (dist_left != 0) dist_left--;
               if (dist_left == 0) complete = 1'b1;
            end
            if (complete) begin
               run_time   += time_delta;
               run_dist   += digit_acc;
               time_delta = '0;
               digit_acc  = '0;
               dec_phase  = PhaseWidth;
               res                = '0;
               res.result_kind    = KindEvent;
               res.event_time     = run_time;
               res.event_distance = run_dist;
               res.status         = StatusOk;
               add_result(res);
            end else if (r.last_char) begin
               // string ends inside a record
               parse_stopped = 1'b1;
               dec_phase     = PhaseStopped;
            end
         end
         default: dec_phase = PhaseStopped;
      endcase
      if (r.last_char) begin
         res             = '0;
         res.result_kind = KindStatus;
         res.last_result = 1'b1;
         if (hdr_bad) begin
            res.status = StatusBadHeader;
         end else if (start_phase == PhaseHeader || start_phase == PhaseCheckHi) begin
            res.status = StatusTooShort;
         end else begin
            res.status        = (check_value[7:0] == char_total) ? StatusOk : StatusChecksum;
            res.stopped_early = parse_stopped;
         end
         add_result(res);
         // the block starts afresh on the next character
         clear_decoder();
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // reporting and idling
   // ---------------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // random wait before the next transaction, with runs of back-to-back traffic
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // ---------------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------------

   // inputs change at the falling edge; the transaction is taken at a rising edge
   // with stall low, and the task returns at the following falling edge
   task automatic send_char(input req_type r);
      int gap;
      gap = draw_wait(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_line(input bit pinned, input logic [1:0] pin_status,
                            input logic pin_stop);
      sent_char_type item;
      for (int i = 0; i < line_chars.size(); i++) begin
         item.req.char_code = line_chars[i];
         item.req.last_char = (i == line_chars.size() - 1);
         item.pinned        = pinned;
         item.pin_status    = pin_status;
         item.pin_stop      = pin_stop;
         chars_in_flight.insert(chars_in_flight.size(), item);
         send_char(item.req);
      end
   endtask

   // random string: mostly well-formed records with random content, the rest noise,
   // degenerate headers, cut-off records, invalid widths and wrong check digits
   function automatic void make_random_line();
      int mode;
      int n_rec;
      int w;
      bit max_digits;
      line_chars.delete();
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
         // plain noise, half of it behind a proper hash
         repeat ($urandom_range(1, 10)) add_char(8'($urandom_range(1, 255)));
         if (mode < 5) line_chars[0] = HashChar;
         return;
      end
      if (mode < 16) begin
         // one to three characters: too short, header only, or bad header
         add_char(mode < 13 ? HashChar : 8'($urandom_range(1, 255)));
         repeat ($urandom_range(0, 2)) add_char(8'($urandom_range(1, 255)));
         return;
      end
      add_char(HashChar);
      add_char("A");
      add_char("A");
      n_rec = $urandom_range(0, 5);
      repeat (n_rec) begin
         // small widths keep strings short; the full range still turns up
         w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 59) : $urandom_range(1, 22);
         max_digits = ($urandom_range(0, 9) == 0);
         add_char(digit_char(w));
         repeat (w % 10 + w / 10) begin
            add_char(max_digits ? digit_char(63) :
                     ($urandom_range(0, 19) == 0) ? non_alpha_char() :
                     digit_char($urandom_range(0, 63)));
         end
      end
      if (mode < 30) begin
         // cut short, usually inside a record
         if (line_chars.size() > 4)
            line_chars = line_chars[0 : $urandom_range(3, line_chars.size() - 2)];
      end else if (mode < 40) begin
         // invalid width followed by a few characters that are only summed
         case ($urandom_range(0, 2))
            0:       add_char(digit_char(0));
            1:       add_char(digit_char($urandom_range(WidthLimit, 63)));
            default: add_char(non_alpha_char());
         endcase
         repeat ($urandom_range(0, 4)) add_char(8'($urandom_range(1, 255)));
      end
      if (mode < 90) begin
         seal_check(1'b1);
      end else begin
         line_chars[1] = 8'($urandom_range(1, 255));
         line_chars[2] = 8'($urandom_range(1, 255));
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // response side: stall drawn per transaction, changed at the falling edge
   // ---------------------------------------------------------------------------------

   initial begin
      int w;
      forever begin
         w = draw_wait(take_quiet);
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------------------
   // scoreboard: predict on every accepted character, then compare any accepted
   // result with the oldest one due; one block so the order within an edge is fixed
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin : scoreboard
      sent_char_type item;
      rsp_type       want;
      if (reset) begin
         clear_decoder();
      end else begin
         if (req_valid && !req_stall) begin
            item = chars_in_flight.pop_front();
            decode_char(req_payload);
            // status fixed by hand replaces the predicted one
            if (item.pinned && item.req.last_char) begin
               void'(results_due.pop_back());
               want                = '0;
               want.result_kind    = KindStatus;
               want.status         = item.pin_status;
               want.stopped_early  = item.pin_stop;
               want.last_result    = 1'b1;
               add_result(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("result with none due: %h", rsp_payload));
            end else begin
               want = results_due.pop_front();
               if (rsp_payload.result_kind !== want.result_kind)
                  report_mismatch($sformatf("result_kind got %0d want %0d",
                                            rsp_payload.result_kind, want.result_kind));
               if (rsp_payload.event_time !== want.event_time)
                  report_mismatch($sformatf("event_time got %0d want %0d",
                                            rsp_payload.event_time, want.event_time));
               if (rsp_payload.event_distance !== want.event_distance)
                  report_mismatch($sformatf("event_distance got %0d want %0d",
                                            rsp_payload.event_distance, want.event_distance));
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_payload.status, want.status));
               if (rsp_payload.stopped_early !== want.stopped_early)
                  report_mismatch($sformatf("stopped_early got %0d want %0d",
                                            rsp_payload.stopped_early, want.stopped_early));
               if (rsp_payload.last_result !== want.last_result)
                  report_mismatch($sformatf("last_result got %0d want %0d",
                                            rsp_payload.last_result, want.last_result));
            end
         end
      end
   end

   // watchdog: too long without a transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------

   initial begin
      int    random_chars;
      string text;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed strings from the table
      foreach (directed_rows[i]) begin
         text = directed_rows[i].text;
         line_chars.delete();
         for (int k = 0; k < text.len(); k++) add_char(text[k]);
         if (directed_rows[i].seal) seal_check(1'b0);
         send_line(directed_rows[i].pinned, directed_rows[i].pin_status,
                   directed_rows[i].pin_stop);
      end

      // random strings, whole strings until enough characters have gone in
      random_chars = 0;
      while (random_chars < RandomChars) begin
         make_random_line();
         random_chars += line_chars.size();
         send_line(1'b0, StatusOk, 1'b0);
      end
      req_valid <= 1'b0;

      // drain, then allow for anything stray still coming out
      while (results_due.size() != 0 || chars_in_flight.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
